### hdl/ipp_pkg.sv
`timescale 1ns / 1ps

package ipp_pkg;

  // Field widths
  localparam int unsigned RATE_W   = 26;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned BPF_W    = 7;
  localparam int unsigned MAXP_W   = 6;
  localparam int unsigned AVAIL_W  = 20;
  localparam int unsigned FB_W     = 24;
  localparam int unsigned BYTES_W  = 17;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned FRAMES_W = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS     = 2'd2;

  // Reset values
  localparam logic [RATE_W-1:0] NOMINAL_RATE_RST    = 26'd3145728;
  localparam logic [BPF_W-1:0]  BYTES_PER_FRAME_RST = 7'd4;
  localparam logic [MAXP_W-1:0] MAX_PACKETS_RST     = 6'd32;

  // Limits
  localparam int unsigned MAX_PACKETS_DEF = 32;
  localparam int unsigned RUN_CAP         = 32;
  localparam logic [BPF_W-1:0] BPF_LIMIT  = 7'd64;

  // Item kinds (tuser)
  localparam logic KIND_SERVICE  = 1'b0;
  localparam logic KIND_FEEDBACK = 1'b1;

endpackage

### hdl/iso_audio_packet_pacer.sv
`timescale 1ns / 1ps

// Isochronous audio packet pacer. A feedback beat (tuser = 1) carries a 10.14 rate in
// in_tdata[43:20]; it sets the 10.16 rate to that word shifted left by two, reloads
// the fraction accumulator and returns nothing. A service beat (tuser = 0) carries the
// FIFO byte count in in_tdata[19:0] and yields one result beat per packet, tlast on the
// final one; a run that fits no packet yields nothing. One packet is sized and checked
// at a time by a single multiply/subtract path stepped by a small sequencer, and
// in_tready stays low until the run ends. Writing nominal_rate reloads the rate and the
// accumulator; configuration must be written only while the block is idle, which the
// block itself does not enforce.
module iso_audio_packet_pacer #(
  parameter int unsigned MAX_PACKETS = ipp_pkg::MAX_PACKETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [ipp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipp_pkg::RATE_W-1:0]        cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ipp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [19:0] avail_bytes, [43:20] feedback_word
  input  logic                              in_tuser,   // [0] kind
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ipp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [16:0] packet_bytes, [21:17] packet_index
  output logic                              out_tlast
);

  localparam int unsigned CAP = (MAX_PACKETS < ipp_pkg::RUN_CAP) ? MAX_PACKETS
                                                                   : ipp_pkg::RUN_CAP;
  localparam logic [ipp_pkg::MAXP_W-1:0] CAP_V = ipp_pkg::MAXP_W'(CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_TEST,
    S_OUT,
    S_TAKE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ipp_pkg::RATE_W-1:0]      rate_r, rate_nxt;
  logic [ipp_pkg::FRAC_W-1:0]      frac_r, frac_nxt;
  logic [ipp_pkg::BPF_W-1:0]       bpf_r, bpf_nxt;
  logic [ipp_pkg::MAXP_W-1:0]      maxp_r, maxp_nxt;
  logic [ipp_pkg::AVAIL_W-1:0]     avail_r, avail_nxt;
  logic [ipp_pkg::BYTES_W-1:0]     size_r, size_nxt;
  logic [ipp_pkg::FRAC_W-1:0]      sum_r, sum_nxt;
  logic [ipp_pkg::MAXP_W-1:0]      n_r, n_nxt;
  logic                            pend_r, pend_nxt;
  logic                            ok_r, ok_nxt;
  logic [ipp_pkg::BYTES_W-1:0]     pend_bytes_r, pend_bytes_nxt;
  logic [ipp_pkg::INDEX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ipp_pkg::BYTES_W-1:0]     out_bytes_r, out_bytes_nxt;
  logic [ipp_pkg::INDEX_W-1:0]     out_idx_r, out_idx_nxt;
  logic                            out_last_r, out_last_nxt;

  // shared datapath
  logic [ipp_pkg::FRAC_W:0]        acc_sum;
  logic [ipp_pkg::FRAMES_W-1:0]    frames;
  logic [ipp_pkg::BPF_W-1:0]       bpf_eff;
  logic [ipp_pkg::FRAMES_W+ipp_pkg::BPF_W-1:0] prod;
  logic [ipp_pkg::AVAIL_W:0]       diff;
  logic [ipp_pkg::MAXP_W-1:0]      limit;
  logic                            fits;

  logic [ipp_pkg::AVAIL_W-1:0]     in_avail;
  logic [ipp_pkg::FB_W-1:0]        in_fb;

  assign in_avail = in_tdata[ipp_pkg::AVAIL_W-1:0];
  assign in_fb    = in_tdata[ipp_pkg::AVAIL_W+ipp_pkg::FB_W-1:ipp_pkg::AVAIL_W];

  // packet size: integer frames plus accumulator carry, times bytes per frame
  assign acc_sum = {1'b0, frac_r} + {1'b0, rate_r[ipp_pkg::FRAC_W-1:0]};
  assign frames  = ipp_pkg::FRAMES_W'(rate_r[ipp_pkg::RATE_W-1:ipp_pkg::FRAC_W])
                 + ipp_pkg::FRAMES_W'(acc_sum[ipp_pkg::FRAC_W]);
  assign bpf_eff = (bpf_r > ipp_pkg::BPF_LIMIT) ? ipp_pkg::BPF_LIMIT : bpf_r;
  assign prod    = {{ipp_pkg::BPF_W{1'b0}}, frames} * {{ipp_pkg::FRAMES_W{1'b0}}, bpf_eff};

  // remaining bytes after this packet; borrow means it does not fit
  assign diff  = {1'b0, avail_r} - {{(ipp_pkg::AVAIL_W+1-ipp_pkg::BYTES_W){1'b0}}, size_r};
  assign limit = (maxp_r < CAP_V) ? maxp_r : CAP_V;
  assign fits  = !diff[ipp_pkg::AVAIL_W] && (n_r < limit);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(ipp_pkg::OUT_TDATA_W-ipp_pkg::BYTES_W-ipp_pkg::INDEX_W){1'b0}},
                       out_idx_r, out_bytes_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    rate_nxt       = rate_r;
    frac_nxt       = frac_r;
    bpf_nxt        = bpf_r;
    maxp_nxt       = maxp_r;
    avail_nxt      = avail_r;
    size_nxt       = size_r;
    sum_nxt        = sum_r;
    n_nxt          = n_r;
    pend_nxt       = pend_r;
    ok_nxt         = ok_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r;
    out_bytes_nxt  = out_bytes_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        ipp_pkg::REG_NOMINAL_RATE: begin
          rate_nxt = cfg_data;
          frac_nxt = cfg_data[ipp_pkg::FRAC_W-1:0];
        end
        ipp_pkg::REG_BYTES_PER_FRAME: bpf_nxt  = cfg_data[ipp_pkg::BPF_W-1:0];
        ipp_pkg::REG_MAX_PACKETS:     maxp_nxt = cfg_data[ipp_pkg::MAXP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == ipp_pkg::KIND_FEEDBACK) begin
            rate_nxt = {in_fb, 2'b00};
            frac_nxt = {in_fb[ipp_pkg::FRAC_W-3:0], 2'b00};
          end else begin
            avail_nxt = in_avail;
            n_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        size_nxt  = prod[ipp_pkg::BYTES_W-1:0];
        sum_nxt   = acc_sum[ipp_pkg::FRAC_W-1:0];
        state_nxt = S_TEST;
      end
      S_TEST: begin
        ok_nxt = fits;
        if (pend_r) begin
          // the held packet goes out now; last unless another one fits
          out_valid_nxt = 1'b1;
          out_bytes_nxt = pend_bytes_r;
          out_idx_nxt   = pend_idx_r;
          out_last_nxt  = !fits;
          state_nxt     = S_OUT;
        end else if (fits) begin
          state_nxt = S_TAKE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ok_r ? S_TAKE : S_IDLE;
        end
      end
      S_TAKE: begin
        // commit the packet and advance the accumulator
        pend_bytes_nxt = size_r;
        pend_idx_nxt   = n_r[ipp_pkg::INDEX_W-1:0];
        pend_nxt       = 1'b1;
        avail_nxt      = diff[ipp_pkg::AVAIL_W-1:0];
        frac_nxt       = sum_r;
        n_nxt          = n_r + ipp_pkg::MAXP_W'(1);
        state_nxt      = S_SIZE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= ipp_pkg::NOMINAL_RATE_RST;
      frac_r      <= ipp_pkg::NOMINAL_RATE_RST[ipp_pkg::FRAC_W-1:0];
      bpf_r       <= ipp_pkg::BYTES_PER_FRAME_RST;
      maxp_r      <= ipp_pkg::MAX_PACKETS_RST;
      n_r         <= '0;
      pend_r      <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      frac_r      <= frac_nxt;
      bpf_r       <= bpf_nxt;
      maxp_r      <= maxp_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    avail_r      <= avail_nxt;
    size_r       <= size_nxt;
    sum_r        <= sum_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  // checks
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> state_r == S_IDLE)
    else $error("run continued after last packet");

  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && state_r != S_IDLE |-> n_r != '0)
    else $error("held packet with zero count");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> n_r <= limit)
    else $error("packet count above limit");

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT)
    else $error("result valid outside output state");

endmodule

### test/tb_iso_audio_packet_pacer.sv
`timescale 1ns / 1ps

module tb_iso_audio_packet_pacer;
  import ipp_pkg::*;

  // unused register index, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned QUIET_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [BYTES_W-1:0] nbytes;
    logic [INDEX_W-1:0] pos;
    logic               is_last;
  } packet_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [RATE_W-1:0]      cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [19:0] avail_bytes, [43:20] feedback_word
  logic                   in_tuser;   // [0] kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [16:0] packet_bytes, [21:17] packet_index
  logic                   out_tlast;

  // pacer state as predicted
  logic [RATE_W-1:0]  cur_rate;
  logic [FRAC_W-1:0]  acc_frac;
  logic [BPF_W-1:0]   set_bpf;
  logic [MAXP_W-1:0]  set_maxp;

  packet_t     due_packets[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  bit          idle_en = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_stall_left = 0;

  iso_audio_packet_pacer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // size of the next packet from the current rate and accumulator
  function automatic logic [BYTES_W-1:0] next_packet_size();
    logic [FRAC_W:0]     sum;
    logic [FRAMES_W-1:0] frames;
    logic [BPF_W-1:0]    bpf;
    sum    = {1'b0, acc_frac} + {1'b0, cur_rate[FRAC_W-1:0]};
    frames = FRAMES_W'(cur_rate[RATE_W-1:FRAC_W]) + FRAMES_W'(sum[FRAC_W]);
    bpf    = (set_bpf > BPF_LIMIT) ? BPF_LIMIT : set_bpf;
    return BYTES_W'(frames) * BYTES_W'(bpf);
  endfunction

  // queue the packets of one service run; the accumulator moves only on emitted packets
  function automatic void predict_service(input logic [AVAIL_W-1:0] avail);
    logic [AVAIL_W-1:0] left;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] next_size;
    int unsigned        cap;
    int unsigned        n;
    packet_t            pkt;
    cap = (set_maxp > RUN_CAP) ? RUN_CAP : set_maxp;
    if (cap > MAX_PACKETS_DEF) cap = MAX_PACKETS_DEF;
    left = avail;
    n    = 0;
    size = next_packet_size();
    while (n < cap && AVAIL_W'(size) <= left) begin
      left      = left - AVAIL_W'(size);
      acc_frac  = acc_frac + cur_rate[FRAC_W-1:0];
      next_size = next_packet_size();
      pkt.nbytes  = size;
      pkt.pos     = INDEX_W'(n);
      pkt.is_last = !((n + 1 < cap) && (AVAIL_W'(next_size) <= left));
      due_packets.push_back(pkt);
      n++;
      size = next_size;
    end
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // offer one beat from a falling edge, predict at the accepting edge
  task automatic send_item(input logic kind, input logic [AVAIL_W-1:0] avail,
                           input logic [FB_W-1:0] fb);
    in_tuser  = kind;
    in_tdata  = {{(IN_TDATA_W - FB_W - AVAIL_W){1'b0}}, fb, avail};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (kind == KIND_FEEDBACK) begin
      cur_rate = {fb, 2'b00};
      acc_frac = cur_rate[FRAC_W-1:0];
    end else begin
      predict_service(avail);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    if (idle_en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_NOMINAL_RATE: begin
        cur_rate = value;
        acc_frac = value[FRAC_W-1:0];
      end
      REG_BYTES_PER_FRAME: set_bpf = value[BPF_W-1:0];
      REG_MAX_PACKETS:     set_maxp = value[MAXP_W-1:0];
      default: ;
    endcase
  endtask

  // wait for every packet, then give a run that emits nothing time to finish
  task automatic settle();
    in_tvalid = 1'b0;
    while (due_packets.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // mostly byte counts near a run's worth of packets, some raw and some at boundaries
  function automatic logic [AVAIL_W-1:0] pick_avail();
    longint unsigned unit;
    longint unsigned want;
    unit = next_packet_size();
    case ($urandom_range(0, 9))
      0: want = $urandom_range(0, 20'hFFFFF);
      1: want = unit * $urandom_range(0, 3);
      2: want = (unit == 0) ? 0 : unit - 1;
      default: want = unit * $urandom_range(0, 34) + $urandom_range(0, int'(unit));
    endcase
    if (want > 20'hFFFFF) want = 20'hFFFFF;
    return AVAIL_W'(want);
  endfunction

  // realistic 10.14 rates most of the time, any word now and then
  function automatic logic [FB_W-1:0] pick_feedback();
    if ($urandom_range(0, 3) == 0) return FB_W'($urandom());
    return {10'($urandom_range(1, 64)), 14'($urandom())};
  endfunction

  task automatic shuffle_config();
    settle();
    if ($urandom_range(0, 3) == 0) write_reg(REG_NOMINAL_RATE, RATE_W'($urandom()));
    else write_reg(REG_NOMINAL_RATE, {10'($urandom_range(1, 64)), 16'($urandom())});
    if ($urandom_range(0, 4) == 0) write_reg(REG_BYTES_PER_FRAME, RATE_W'($urandom()));
    else write_reg(REG_BYTES_PER_FRAME, RATE_W'($urandom_range(1, 64)));
    if ($urandom_range(0, 4) == 0) write_reg(REG_MAX_PACKETS, RATE_W'($urandom()));
    else write_reg(REG_MAX_PACKETS, RATE_W'($urandom_range(1, 32)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, RATE_W'($urandom()));
  endtask

  // reset settings: 48 frames, 4 bytes each, up to 32 packets
  task automatic test_reset_defaults();
    send_item(KIND_SERVICE, 20'd0, FB_W'($urandom()));
    send_item(KIND_SERVICE, 20'd191, FB_W'($urandom()));
    send_item(KIND_SERVICE, 20'd192, FB_W'($urandom()));
    send_item(KIND_SERVICE, 20'd1000, FB_W'($urandom()));
    send_item(KIND_SERVICE, 20'hFFFFF, FB_W'($urandom()));
  endtask

  task automatic test_feedback_items();
    // zero rate gives zero-length packets up to the limit
    send_item(KIND_FEEDBACK, AVAIL_W'($urandom()), 24'h000000);
    send_item(KIND_SERVICE, 20'd0, FB_W'($urandom()));
    // 44.1 frames per USB frame
    send_item(KIND_FEEDBACK, AVAIL_W'($urandom()), 24'h0B0666);
    send_item(KIND_SERVICE, 20'd2000, FB_W'($urandom()));
    // half a frame: empty and one-frame packets alternate
    send_item(KIND_FEEDBACK, AVAIL_W'($urandom()), 24'h002000);
    send_item(KIND_SERVICE, 20'd20, FB_W'($urandom()));
    // largest rate
    send_item(KIND_FEEDBACK, AVAIL_W'($urandom()), 24'hFFFFFF);
    send_item(KIND_SERVICE, 20'hFFFFF, FB_W'($urandom()));
  endtask

  task automatic test_register_extremes();
    settle();
    // oversized bytes per frame and packet limit saturate; largest packet
    write_reg(REG_BYTES_PER_FRAME, 26'd127);
    write_reg(REG_NOMINAL_RATE, 26'h3FFFFFF);
    write_reg(REG_MAX_PACKETS, 26'd63);
    send_item(KIND_SERVICE, 20'hFFFFF, FB_W'($urandom()));
    settle();
    // zero bytes per frame, upper data bits ignored
    write_reg(REG_BYTES_PER_FRAME, 26'h3FFFF80);
    send_item(KIND_SERVICE, 20'd5, FB_W'($urandom()));
    settle();
    // packet limit of zero emits nothing
    write_reg(REG_MAX_PACKETS, 26'd0);
    send_item(KIND_SERVICE, 20'hFFFFF, FB_W'($urandom()));
    settle();
    write_reg(REG_MAX_PACKETS, 26'd1);
    write_reg(REG_BYTES_PER_FRAME, 26'd1);
    write_reg(REG_NOMINAL_RATE, 26'd0);
    send_item(KIND_SERVICE, 20'd0, FB_W'($urandom()));
    settle();
    // write to an unused index changes nothing
    write_reg(REG_MAX_PACKETS, 26'd32);
    write_reg(REG_BYTES_PER_FRAME, 26'd64);
    write_reg(REG_NOMINAL_RATE, 26'h0010000);
    write_reg(REG_UNMAPPED, 26'h3FFFFFF);
    send_item(KIND_SERVICE, 20'd197, FB_W'($urandom()));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        send_item(KIND_FEEDBACK, AVAIL_W'($urandom()), pick_feedback());
      else
        send_item(KIND_SERVICE, pick_avail(), FB_W'($urandom()));
    end
  endtask

  // receiver holds off so the sender stalls on full runs, then waits for a full drain
  task automatic test_backpressure();
    settle();
    write_reg(REG_NOMINAL_RATE, NOMINAL_RATE_RST);
    write_reg(REG_BYTES_PER_FRAME, 26'd4);
    write_reg(REG_MAX_PACKETS, 26'd32);
    rx_hold_req = 1'b1;
    repeat (8) send_item(KIND_SERVICE, 20'hFFFFF, FB_W'($urandom()));
    settle();
    repeat (8) send_item(KIND_SERVICE, pick_avail(), FB_W'($urandom()));
    settle();
  endtask

  // result side pacing, stalls counted here
  initial begin : rx_pacing
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req   = 1'b0;
        rx_stall_left = RX_HOLD_CYCLES;
      end else if (rx_stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        rx_stall_left = $urandom_range(1, 18);
      end
      if (rx_stall_left != 0) begin
        out_tready = 1'b0;
        rx_stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // compare each result beat with the oldest predicted packet
  always @(posedge clk) begin : result_check
    packet_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (due_packets.size() == 0) begin
        flag_mismatch("result beat with no packet due", out_tdata[BYTES_W-1:0], 0);
      end else begin
        want = due_packets.pop_front();
        if (out_tdata[BYTES_W-1:0] !== want.nbytes)
          flag_mismatch("packet_bytes", out_tdata[BYTES_W-1:0], want.nbytes);
        if (out_tdata[BYTES_W+INDEX_W-1:BYTES_W] !== want.pos)
          flag_mismatch("packet_index", out_tdata[BYTES_W+INDEX_W-1:BYTES_W], want.pos);
        if (out_tlast !== want.is_last)
          flag_mismatch("tlast", out_tlast, want.is_last);
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_SERVICE;
    cur_rate  = NOMINAL_RATE_RST;
    acc_frac  = NOMINAL_RATE_RST[FRAC_W-1:0];
    set_bpf   = BYTES_PER_FRAME_RST;
    set_maxp  = MAX_PACKETS_RST;
    repeat (5) @(negedge clk);
    rst_n   = 1'b1;
    idle_en = 1'b1;

    test_reset_defaults();
    test_feedback_items();
    test_register_extremes();
    repeat (6) begin
      shuffle_config();
      test_random_traffic(55);
    end
    test_backpressure();

    // closing stretch with both sides streaming
    idle_en = 1'b0;
    shuffle_config();
    test_random_traffic(60);
    settle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
